/* sv/nbg_pkg.sv */
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared types and constants of the single-body gravity integrator.
// ----------------------------------------------------------------------------
package nbg_pkg;

  // input item modes
  typedef enum logic [1:0] {
    MODE_LOAD_POS = 2'd0,
    MODE_LOAD_VEL = 2'd1,
    MODE_GRAVITY  = 2'd2,
    MODE_ADVANCE  = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_R2S,
    ST_KMUL,
    ST_DIVU,
    ST_MULP,
    ST_DIVQ,
    ST_SAT,
    ST_ADV_MUL,
    ST_ADV_ADD
  } state_e;

  // register index (address bit 2)
  localparam logic REG_GRAV_CONST = 1'b0;
  localparam logic REG_TIME_STEP  = 1'b1;

  // register reset values, unsigned Q8.24 one
  localparam logic [31:0] GRAV_CONST_RESET = 32'h0100_0000;
  localparam logic [31:0] TIME_STEP_RESET  = 32'h0100_0000;

endpackage

/* sv/nbody_gravity_step_core.sv */
// ----------------------------------------------------------------------------
// nbody_gravity_step_core
// Holds one body's position and velocity and applies loads, gravity pulls
// from other bodies and Euler position steps.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Position and velocity
// loads offer their result in the cycle after the transfer. An advance step
// does two partial products and one add per axis. A gravity item shifts the
// distance down by a normalizing shift s (0 to 2 at a coordinate width of
// 32 bits, up to 34 at 64 bits); all of it runs through one 32x32
// multiplier with accumulator and one bit-serial shift/subtract unit that
// does the square root (one result bit a cycle) and both divisions (one
// quotient bit a cycle). A coincident body offers its result in the cycle
// after the transfer. No new item is taken while a result waits and is not
// transferred.
module nbody_gravity_step_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [23:0]        other_mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic               coincident_o
);
  import nbg_pkg::*;

  localparam int DW = (COORD_WIDTH < 64) ? COORD_WIDTH + 1 : 64;
  localparam int SW = $clog2(DW + 1);
  localparam logic signed [65:0] VMAX = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] VMIN = -VMAX - 66'sd1;

  // configuration registers
  logic [31:0] grav_q, dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAV_CONST_RESET;
      dt_q   <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_GRAV_CONST: grav_q <= pwdata;
        REG_TIME_STEP:  dt_q   <= pwdata;
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_TIME_STEP) ? dt_q : grav_q;
  assign pready = 1'b1;

  // state and datapath registers
  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic coin_q, coin_d;
  logic [1:0] ax_q, ax_d, sub_q, sub_d;
  logic [6:0] cnt_q, cnt_d;
  logic [SW-1:0] s_q, s_d;
  logic signed [COORD_WIDTH-1:0] pos_q [3], pos_d [3], vel_q [3], vel_d [3];
  logic [DW-1:0] mag_q [3], mag_d [3];
  logic neg_q [3], neg_d [3];
  logic [95:0] acc_q, acc_d, num_q, num_d;
  logic [63:0] rem_q, rem_d, kmul_q, kmul_d;
  logic [61:0] quo_q, quo_d, r2s_q, r2s_d;
  logic big_q, big_d;
  logic [30:0] rs_q, rs_d;
  logic [23:0] mass_q, mass_d;

  // input vectors reduced to the coordinate width
  logic signed [31:0] cin [3];
  logic signed [COORD_WIDTH-1:0] oth [3];
  logic [DW-1:0] diff [3], dmag [3];
  logic dneg [3];
  logic [29:0] ds [3];
  logic dzero, any_big;

  assign cin[0] = coord_x_i;
  assign cin[1] = coord_y_i;
  assign cin[2] = coord_z_i;

  // distance to the other body, sign and magnitude per axis
  always_comb begin
    dzero   = 1'b1;
    any_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      oth[i]  = COORD_WIDTH'(cin[i]);
      diff[i] = DW'(oth[i]) - DW'(pos_q[i]);
      dneg[i] = diff[i][DW-1];
      dmag[i] = dneg[i] ? (~diff[i] + 1'b1) : diff[i];
      dzero   = dzero && (dmag[i] == '0);
      any_big = any_big || ((mag_q[i] >> 30) != '0);
      ds[i]   = 30'(mag_q[i]);
    end
  end

  // shared multiplier with accumulator
  logic [31:0] mul_a, mul_b;
  logic mul_hi, mul_clr;
  logic [63:0] prod;
  logic [95:0] acc_sum;

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = (mul_clr ? 96'd0 : acc_q) + (mul_hi ? {prod, 32'd0} : 96'(prod));

  // shared shift/subtract unit: root digit step and quotient bit step
  logic [63:0] rem_s2, trial, rem_s1, dvs;
  logic ge2, ge1;

  assign rem_s2 = {rem_q[61:0], num_q[95:94]};
  assign trial  = {31'd0, quo_q[30:0], 2'b01};
  assign ge2    = rem_s2 >= trial;
  assign rem_s1 = {rem_q[62:0], num_q[95]};
  assign dvs    = (state_q == ST_DIVU) ? 64'(rs_q) : 64'(r2s_q);
  assign ge1    = rem_s1 >= dvs;

  // velocity magnitude for the advance step
  logic signed [64:0] v_ext;
  logic [63:0] v_mag;
  logic [95:0] adv_prod;
  logic [COORD_WIDTH-1:0] adv_step;

  assign v_ext    = 65'(vel_q[ax_q]);
  assign v_mag    = v_ext[64] ? 64'(-v_ext) : 64'(v_ext);
  assign adv_prod = v_ext[64] ? (~acc_q + 96'd1) : acc_q;
  assign adv_step = adv_prod[24 +: COORD_WIDTH];

  // saturating velocity update
  logic [62:0] qv;
  logic signed [65:0] v_wide, q_wide, v_sum;
  logic signed [COORD_WIDTH-1:0] v_sat;

  assign qv     = big_q ? (63'd1 << 62) : 63'(quo_q);
  assign v_wide = 66'(vel_q[ax_q]);
  assign q_wide = $signed({3'd0, qv});
  assign v_sum  = neg_q[ax_q] ? (v_wide - q_wide) : (v_wide + q_wide);

  always_comb begin
    if (v_sum > VMAX) begin
      v_sat = COORD_WIDTH'(VMAX);
    end else if (v_sum < VMIN) begin
      v_sat = COORD_WIDTH'(VMIN);
    end else begin
      v_sat = COORD_WIDTH'(v_sum);
    end
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    coin_d      = coin_q;
    ax_d        = ax_q;
    sub_d       = sub_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    num_d       = num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    big_d       = big_q;
    rs_d        = rs_q;
    r2s_d       = r2s_q;
    kmul_d      = kmul_q;
    mass_d      = mass_q;
    mul_a       = '0;
    mul_b       = '0;
    mul_hi      = 1'b0;
    mul_clr     = 1'b1;
    in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          coin_d = 1'b0;
          unique case (mode_e'(mode_i))
            MODE_LOAD_POS: begin
              for (int i = 0; i < 3; i++) pos_d[i] = oth[i];
              out_valid_d = 1'b1;
            end
            MODE_LOAD_VEL: begin
              for (int i = 0; i < 3; i++) vel_d[i] = oth[i];
              out_valid_d = 1'b1;
            end
            MODE_GRAVITY: begin
              mag_d  = dmag;
              neg_d  = dneg;
              s_d    = '0;
              mass_d = other_mass_i;
              if (dzero) begin
                coin_d      = 1'b1;
                out_valid_d = 1'b1;
              end else begin
                state_d = ST_NORM;
              end
            end
            MODE_ADVANCE: begin
              ax_d    = 2'd0;
              sub_d   = 2'd0;
              state_d = ST_ADV_MUL;
            end
            default: ;
          endcase
        end
      end
      // shift the distance down until every axis is below 2^30
      ST_NORM: begin
        if (any_big) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
          s_d = s_q + 1'b1;
        end else begin
          sub_d   = 2'd0;
          state_d = ST_SQ;
        end
      end
      // sum of squares
      ST_SQ: begin
        mul_a   = 32'(ds[sub_q]);
        mul_b   = 32'(ds[sub_q]);
        mul_clr = (sub_q == 2'd0);
        acc_d   = acc_sum;
        if (sub_q == 2'd2) begin
          num_d   = {acc_sum[61:0], 34'd0};
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = 7'd30;
          state_d = ST_SQRT;
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      // integer square root, one result bit a cycle
      ST_SQRT: begin
        rem_d = ge2 ? (rem_s2 - trial) : rem_s2;
        quo_d = {quo_q[60:0], ge2};
        num_d = num_q << 2;
        if (cnt_q == 7'd0) begin
          rs_d    = quo_d[30:0];
          state_d = ST_R2S;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      // squared root
      ST_R2S: begin
        mul_a   = 32'(rs_q);
        mul_b   = 32'(rs_q);
        r2s_d   = acc_sum[61:0];
        sub_d   = 2'd0;
        state_d = ST_KMUL;
      end
      // floor(G*dt / 2^24) * mass
      ST_KMUL: begin
        unique case (sub_q)
          2'd0: begin
            mul_a  = grav_q;
            mul_b  = dt_q;
            kmul_d = 64'(acc_sum[63:24]);
            sub_d  = 2'd1;
          end
          2'd1: begin
            mul_a = kmul_q[31:0];
            mul_b = 32'(mass_q);
            acc_d = acc_sum;
            sub_d = 2'd2;
          end
          2'd2: begin
            mul_a   = 32'(kmul_q[39:32]);
            mul_b   = 32'(mass_q);
            mul_hi  = 1'b1;
            mul_clr = 1'b0;
            kmul_d  = acc_sum[63:0];
            ax_d    = 2'd0;
            num_d   = {ds[0], 66'd0};
            rem_d   = '0;
            quo_d   = '0;
            big_d   = 1'b0;
            cnt_d   = 7'd59;
            state_d = ST_DIVU;
          end
          default: ;
        endcase
      end
      // quotient bit steps for the unit vector and for the velocity delta
      ST_DIVU, ST_DIVQ: begin
        rem_d = ge1 ? (rem_s1 - dvs) : rem_s1;
        quo_d = {quo_q[60:0], ge1};
        big_d = big_q || (ge1 && (cnt_q >= 7'd62));
        num_d = num_q << 1;
        if (cnt_q == 7'd0) begin
          sub_d   = 2'd0;
          state_d = (state_q == ST_DIVU) ? ST_MULP : ST_SAT;
        end else begin
          cnt_d = cnt_q - 7'd1;
        end
      end
      // K times unit component, two partial products
      ST_MULP: begin
        mul_b = 32'(quo_q[30:0]);
        acc_d = acc_sum;
        if (sub_q == 2'd0) begin
          mul_a = kmul_q[31:0];
          sub_d = 2'd1;
        end else begin
          mul_a   = kmul_q[63:32];
          mul_hi  = 1'b1;
          mul_clr = 1'b0;
          num_d   = acc_sum;
          rem_d   = '0;
          quo_d   = '0;
          big_d   = 1'b0;
          cnt_d   = 7'(77 - 2 * int'(s_q));
          state_d = ST_DIVQ;
        end
      end
      // apply the delta to one velocity axis
      ST_SAT: begin
        vel_d[ax_q] = v_sat;
        if (ax_q == 2'd2) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          ax_d    = ax_q + 2'd1;
          num_d   = {ds[2'(ax_q + 2'd1)], 66'd0};
          rem_d   = '0;
          quo_d   = '0;
          big_d   = 1'b0;
          cnt_d   = 7'd59;
          state_d = ST_DIVU;
        end
      end
      // |v| * dt, two partial products
      ST_ADV_MUL: begin
        mul_b = dt_q;
        acc_d = acc_sum;
        if (sub_q == 2'd0) begin
          mul_a = v_mag[31:0];
          sub_d = 2'd1;
        end else begin
          mul_a   = v_mag[63:32];
          mul_hi  = 1'b1;
          mul_clr = 1'b0;
          state_d = ST_ADV_ADD;
        end
      end
      // wrapping position add
      ST_ADV_ADD: begin
        pos_d[ax_q] = pos_q[ax_q] + $signed(adv_step);
        if (ax_q == 2'd2) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          ax_d    = ax_q + 2'd1;
          sub_d   = 2'd0;
          state_d = ST_ADV_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and body state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      coin_q      <= 1'b0;
      ax_q        <= 2'd0;
      sub_q       <= 2'd0;
      cnt_q       <= 7'd0;
      s_q         <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      coin_q      <= coin_d;
      ax_q        <= ax_d;
      sub_q       <= sub_d;
      cnt_q       <= cnt_d;
      s_q         <= s_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    big_q  <= big_d;
    rs_q   <= rs_d;
    r2s_q  <= r2s_d;
    kmul_q <= kmul_d;
    mass_q <= mass_d;
  end

  // result ports
  assign out_valid_o  = out_valid_q;
  assign coincident_o = coin_q;
  assign pos_x_o      = 32'(pos_q[0]);
  assign pos_y_o      = 32'(pos_q[1]);
  assign pos_z_o      = 32'(pos_q[2]);
  assign vel_x_o      = 32'(vel_q[0]);
  assign vel_y_o      = 32'(vel_q[1]);
  assign vel_z_o      = 32'(vel_q[2]);

  // checks
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending while busy");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_LOAD_POS || mode_i == MODE_LOAD_VEL))
    |=> out_valid_o)
    else $error("load transfer gave no result");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
    ($stable(pos_x_o) && $stable(vel_x_o) && $stable(coincident_o)))
    else $error("result changed while waiting");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVQ && cnt_q != 7'd0) |=> (state_q == ST_DIVQ))
    else $error("division left early");

  a_norm_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> !any_big)
    else $error("distance not normalized");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-body gravity integrator: a directed
// table of loads, gravity pulls and advance steps, then random phases under
// several constant and time step settings, with results checked per field
// against a bit-exact fixed point model of the body held in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import nbg_pkg::*;

  typedef struct {
    logic [31:0] px, py, pz, vx, vy, vz;
    logic        hit;
  } body_state_t;

  typedef struct {
    mode_e              mode;
    logic signed [31:0] x, y, z;
    logic [23:0]        mass;
    bit                 typed;
    body_state_t        want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i = MODE_LOAD_POS;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic [23:0]        other_mass_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  logic               coincident_o;

  nbody_gravity_step_core u_dut (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // body model state and register copies
  logic signed [63:0] body_pos [3];
  logic signed [63:0] body_vel [3];
  logic [31:0]        g_const_q;
  logic [31:0]        dt_q;
  body_state_t        pending_q [$];
  stim_row_t          plan_q [$];
  int                 fail_cnt = 0;
  bit                 calm = 1'b0;

  function automatic logic signed [63:0] wrap32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // velocity kick from one other body; returns 1 when it sits on this body
  function automatic bit apply_pull(logic signed [31:0] c [3], logic [23:0] m);
    logic [63:0]        mag [3];
    logic [63:0]        ds [3];
    bit                 neg [3];
    logic signed [63:0] d, t, qs;
    logic [63:0]        mx, r2, rs, r2s, gd, kmul, u;
    logic [127:0]       prod, quo;
    int                 s;
    mx = '0;
    r2 = '0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(c[i]) - body_pos[i];
      neg[i] = d < 0;
      mag[i] = d < 0 ? -d : d;
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 1'b1;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      ds[i] = mag[i] >> s;
      r2 = r2 + ds[i] * ds[i];
    end
    rs = int_sqrt(r2);
    if (rs == 0) return 1'b1;
    r2s = rs * rs;
    gd = 64'(g_const_q) * 64'(dt_q);
    kmul = (gd >> 24) * {40'b0, m};
    for (int i = 0; i < 3; i++) begin
      u = (ds[i] << 30) / rs;
      prod = 128'(kmul) * 128'(u);
      quo = (prod >> (18 + 2 * s)) / 128'(r2s);
      qs = (quo >= (128'd1 << 62)) ? (64'sd1 <<< 62) : quo[63:0];
      t = neg[i] ? body_vel[i] - qs : body_vel[i] + qs;
      // saturate to the 32-bit signed range
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      body_vel[i] = t;
    end
    return 1'b0;
  endfunction

  // state update for one accepted item, returns the expected result
  function automatic body_state_t body_step(stim_row_t r);
    logic signed [31:0]  c [3];
    logic signed [127:0] vw, tw, p;
    body_state_t         res;
    bit                  hit;
    hit = 1'b0;
    c[0] = r.x;
    c[1] = r.y;
    c[2] = r.z;
    case (r.mode)
      MODE_LOAD_POS: for (int i = 0; i < 3; i++) body_pos[i] = c[i];
      MODE_LOAD_VEL: for (int i = 0; i < 3; i++) body_vel[i] = c[i];
      MODE_GRAVITY:  hit = apply_pull(c, r.mass);
      default: begin
        for (int i = 0; i < 3; i++) begin
          vw = body_vel[i];
          tw = {96'b0, dt_q};
          p = (vw * tw) >>> 24;
          body_pos[i] = wrap32(body_pos[i] + p[63:0]);
        end
      end
    endcase
    res.px = body_pos[0][31:0];
    res.py = body_pos[1][31:0];
    res.pz = body_pos[2][31:0];
    res.vx = body_vel[0][31:0];
    res.vy = body_vel[1][31:0];
    res.vz = body_vel[2][31:0];
    res.hit = hit;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    body_state_t w;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_cnt++;
      end else begin
        w = pending_q.pop_front();
        if (pos_x_o !== w.px) begin
          $error("pos_x exp %h got %h", w.px, pos_x_o); fail_cnt++;
        end
        if (pos_y_o !== w.py) begin
          $error("pos_y exp %h got %h", w.py, pos_y_o); fail_cnt++;
        end
        if (pos_z_o !== w.pz) begin
          $error("pos_z exp %h got %h", w.pz, pos_z_o); fail_cnt++;
        end
        if (vel_x_o !== w.vx) begin
          $error("vel_x exp %h got %h", w.vx, vel_x_o); fail_cnt++;
        end
        if (vel_y_o !== w.vy) begin
          $error("vel_y exp %h got %h", w.vy, vel_y_o); fail_cnt++;
        end
        if (vel_z_o !== w.vz) begin
          $error("vel_z exp %h got %h", w.vz, vel_z_o); fail_cnt++;
        end
        if (coincident_o !== w.hit) begin
          $error("coincident exp %b got %b", w.hit, coincident_o); fail_cnt++;
        end
      end
    end
  end

  // result side stalls
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) < 6) begin
      out_ready_i <= 1'b1;
    end else begin
      stall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                              : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end
  end

  task automatic reg_write(logic reg_idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_GRAV_CONST) g_const_q = val;
    else dt_q = val;
  endtask

  // drain all results before touching registers
  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // one input transfer, followed by an optional gap
  task automatic send_item(stim_row_t r, int gap);
    body_state_t w;
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    coord_x_i <= r.x;
    coord_y_i <= r.y;
    coord_z_i <= r.z;
    other_mass_i <= r.mass;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    w = body_step(r);
    pending_q.push_back(r.typed ? r.want : w);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 70);
  endfunction

  function automatic stim_row_t mk_row(mode_e md, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic [23:0] m);
    stim_row_t r;
    r.mode = md;
    r.x = x;
    r.y = y;
    r.z = z;
    r.mass = m;
    r.typed = 1'b0;
    r.want = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t mk_typed(stim_row_t r, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [31:0] vx,
                                         logic [31:0] vy, logic [31:0] vz, logic hit);
    r.typed = 1'b1;
    r.want = '{px, py, pz, vx, vy, vz, hit};
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 ** 16)) - 2 ** 15);
    endcase
  endfunction

  // another body somewhere around this one, now and then exactly on it
  function automatic logic [31:0] near_coord(logic signed [63:0] own);
    int sh;
    sh = $urandom_range(0, 31);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return own[31:0] + 32'($signed($urandom()) >>> sh);
  endfunction

  function automatic logic [23:0] rand_mass();
    case ($urandom_range(0, 4))
      0, 1: return $urandom();
      2, 3: return $urandom_range(0, 1000);
      default: return ($urandom_range(0, 1) != 0) ? 24'hff_ffff : 24'h0;
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    int k;
    k = $urandom_range(0, 99);
    if (k < 12) return mk_row(MODE_LOAD_POS, rand_coord(), rand_coord(), rand_coord(),
                              rand_mass());
    if (k < 22) return mk_row(MODE_LOAD_VEL, rand_coord(), rand_coord(), rand_coord(),
                              rand_mass());
    if (k < 75) begin
      if ($urandom_range(0, 29) == 0)
        return mk_row(MODE_GRAVITY, body_pos[0][31:0], body_pos[1][31:0],
                      body_pos[2][31:0], rand_mass());
      return mk_row(MODE_GRAVITY, near_coord(body_pos[0]), near_coord(body_pos[1]),
                    near_coord(body_pos[2]), rand_mass());
    end
    return mk_row(MODE_ADVANCE, $urandom(), $urandom(), $urandom(), rand_mass());
  endfunction

  // stimulus
  initial begin
    logic [31:0] gset [5];
    logic [31:0] tset [5];
    g_const_q = GRAV_CONST_RESET;
    dt_q = TIME_STEP_RESET;
    for (int i = 0; i < 3; i++) begin
      body_pos[i] = '0;
      body_vel[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset register values
    plan_q.push_back(mk_typed(mk_row(MODE_ADVANCE, 32'h7fff_ffff, 32'h8000_0000, 0, 0),
                              0, 0, 0, 0, 0, 0, 1'b0));
    plan_q.push_back(mk_typed(mk_row(MODE_GRAVITY, 0, 0, 0, 24'hff_ffff),
                              0, 0, 0, 0, 0, 0, 1'b1));
    plan_q.push_back(mk_typed(mk_row(MODE_LOAD_POS, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff, 24'hff_ffff),
                              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 1'b0));
    plan_q.push_back(mk_typed(mk_row(MODE_LOAD_VEL, 32'h8000_0000, 32'h7fff_ffff, 1, 0),
                              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                              32'h8000_0000, 32'h7fff_ffff, 1, 1'b0));
    plan_q.push_back(mk_typed(mk_row(MODE_GRAVITY, 32'h7fff_ffff, 32'h8000_0000,
                                     32'hffff_ffff, 24'h12_3456),
                              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                              32'h8000_0000, 32'h7fff_ffff, 1, 1'b1));
    // zero mass adds nothing
    plan_q.push_back(mk_typed(mk_row(MODE_GRAVITY, 32'h8000_0000, 32'h7fff_ffff, 0, 0),
                              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                              32'h8000_0000, 32'h7fff_ffff, 1, 1'b0));
    // farthest pull, then the heaviest near pull saturating velocity
    plan_q.push_back(mk_row(MODE_GRAVITY, 32'h8000_0000, 32'h7fff_ffff, 0, 24'hff_ffff));
    plan_q.push_back(mk_row(MODE_GRAVITY, 32'h7fff_fffe, 32'h8000_0001, 32'hffff_ffff,
                            24'hff_ffff));
    // position wraps on advance
    plan_q.push_back(mk_row(MODE_ADVANCE, 0, 0, 0, 0));
    plan_q.push_back(mk_row(MODE_LOAD_POS, 0, 0, 0, 0));
    plan_q.push_back(mk_row(MODE_LOAD_VEL, 32'h0000_1000, 32'hffff_f000, 0, 0));
    plan_q.push_back(mk_row(MODE_GRAVITY, 32'h0001_0000, 32'h0002_0000, 32'hfffc_0000, 100));
    plan_q.push_back(mk_row(MODE_GRAVITY, 1, 0, 0, 1));
    plan_q.push_back(mk_row(MODE_ADVANCE, 0, 0, 0, 0));
    plan_q.push_back(mk_row(MODE_GRAVITY, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f,
                            24'haa_aa55));
    plan_q.push_back(mk_row(MODE_ADVANCE, 0, 0, 0, 0));
    foreach (plan_q[i]) send_item(plan_q[i], pick_gap());
    in_valid_i <= 1'b0;
    wait_drained();

    // random phases over several register settings
    gset = '{32'h0100_0000, 32'h0, 32'hffff_ffff, $urandom(), 32'h0000_4000};
    tset = '{32'h0004_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0, $urandom()};
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_GRAV_CONST, gset[ph]);
      reg_write(REG_TIME_STEP, tset[ph]);
      calm = (ph == 1);
      for (int n = 0; n < 380; n++) begin
        send_item(rand_row(), pick_gap());
        if (n == 190) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
      end
      in_valid_i <= 1'b0;
      calm = 1'b0;
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("PASS nbody_gravity_step_core");
    end else begin
      $display("FAIL nbody_gravity_step_core");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(8 * 4_000_000);
    $display("FAIL nbody_gravity_step_core");
    $finish;
  end

endmodule

/* nbody_gravity_step_core.f */
sv/nbg_pkg.sv
sv/nbody_gravity_step_core.sv
tb/sv/tb_top.sv
